[src/dfs_topological_sort_unit_macros.svh]
// ---------------------------------------------------------------------------
// DFS sort assertion macros
// Shared property wrappers for the port checker of the DFS sort unit.
// ---------------------------------------------------------------------------
`ifndef DFS_TOPOLOGICAL_SORT_UNIT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfs checker: same-cycle property failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define DFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfs checker: next-cycle property failed");

`endif

[src/dfs_pkg.sv]
// ---------------------------------------------------------------------------
// DFS sort package
// Sizes, payload structs and shared types of the DFS topological sort unit.
// ---------------------------------------------------------------------------
package dfs_pkg;

    localparam int VERTICES = 64;
    localparam int VW       = $clog2(VERTICES);   // vertex index width
    localparam int CW       = VW + 1;             // count width, holds VERTICES

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    typedef struct packed {
        logic          req_type;
        logic [5:0]    row_index;
        logic [63:0]   row_edges;
    } t_dfs_req;

    typedef struct packed {
        logic [5:0]    vertex;
        logic          last;
    } t_dfs_res;

    // Result of the lowest-set-bit search
    typedef struct packed {
        logic          found;
        logic [VW-1:0] index;
    } t_dfs_pick;

endpackage

[src/dfs_topological_sort_unit.sv]
// ---------------------------------------------------------------------------
// DFS topological sort unit
// Loads adjacency rows and emits a depth-first topological order on request.
// ---------------------------------------------------------------------------
// A load beat (req_type 0) writes one 64-bit adjacency row, and the unit
// stays ready. A run beat (req_type 1) walks the graph of num_vertices
// vertices by depth-first search with an explicit stack, then emits every
// vertex in reverse finish order, one beat per vertex, with last set on the
// final one. Input stall stays high for the whole run. Each push, root
// pushes included, leads to an adjacency memory read and then one pass
// through the shared lowest-bit picker; a pop that leaves a vertex below
// it reads the new stack top, then takes the same read and pass. A pop of
// a tree root returns to the outer loop, which steps past visited roots.
// Each emitted vertex is read from the finish memory, then held until the
// output is free. The adjacency memory read port and the single priority
// encoder set the pace of a run. Rows that were never loaded read as
// undefined data. A num_vertices above 64 acts as 64; zero makes a run
// emit nothing.
// ---------------------------------------------------------------------------
module dfs_topological_sort_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dfs_pkg::t_dfs_req i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dfs_pkg::t_dfs_res o_out_data
);
    import dfs_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_OUTER     = 3'd1;  // pick next root vertex
    localparam logic [2:0] ST_ADJ_RD    = 3'd2;  // wait for adjacency row
    localparam logic [2:0] ST_SCAN      = 3'd3;  // push or pop
    localparam logic [2:0] ST_POP_RD    = 3'd4;  // wait for new stack top
    localparam logic [2:0] ST_EMIT_RD   = 3'd5;  // wait for finish entry
    localparam logic [2:0] ST_EMIT_WAIT = 3'd6;  // hand entry to output reg

    // control registers
    logic [2:0]          r_state,   n_state;
    logic [6:0]          r_num_vertices;
    logic [CW-1:0]       r_n,       n_n;
    logic [CW-1:0]       r_u,       n_u;
    logic [CW-1:0]       r_depth,   n_depth;
    logic [CW-1:0]       r_fcount,  n_fcount;
    logic [VW-1:0]       r_emit_idx, n_emit_idx;
    logic [VW-1:0]       r_top,     n_top;
    logic [VERTICES-1:0] r_visited, n_visited;
    logic [VERTICES-1:0] r_span,    n_span;
    logic                r_out_valid, n_out_valid;
    t_dfs_res            r_out_data,  n_out_data;

    // memories and their registered read data
    logic [VERTICES-1:0] mem_adj [VERTICES];
    logic [VW-1:0]       mem_stk [VERTICES];
    logic [VW-1:0]       mem_fin [VERTICES];
    logic [VERTICES-1:0] r_adj_q;
    logic [VW-1:0]       r_stk_q;
    logic [VW-1:0]       r_fin_q;

    // memory write controls
    logic                adj_we;
    logic                stk_we;
    logic [VW-1:0]       stk_wdata;
    logic                fin_we;
    logic [VW-1:0]       stk_raddr;

    // shared picker
    logic [VERTICES-1:0] cand;
    t_dfs_pick           pick;
    logic [CW-1:0]       cfg_n;
    logic                out_free;
    logic                in_take;

    assign cand = r_adj_q & ~r_visited & r_span;

    dfs_lowbit u_lowbit (
        .i_cand (cand),
        .o_pick (pick)
    );

    // clamp the configured count to the vertex capacity
    assign cfg_n = (r_num_vertices > 7'(VERTICES)) ? CW'(VERTICES) : CW'(r_num_vertices);

    assign in_take   = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign adj_we    = in_take && (i_in_data.req_type == REQ_LOAD);
    // after a pop the new top sits two below the current depth
    assign stk_raddr = VW'(r_depth - CW'(2));

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_u         = r_u;
        n_depth     = r_depth;
        n_fcount    = r_fcount;
        n_emit_idx  = r_emit_idx;
        n_top       = r_top;
        n_visited   = r_visited;
        n_span      = r_span;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        stk_we      = 1'b0;
        stk_wdata   = r_top;
        fin_we      = 1'b0;

        // drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take && (i_in_data.req_type == REQ_RUN)) begin
                    n_n       = cfg_n;
                    n_u       = '0;
                    n_depth   = '0;
                    n_fcount  = '0;
                    n_visited = '0;
                    for (int i = 0; i < VERTICES; i++) begin
                        n_span[i] = (CW'(i) < cfg_n);
                    end
                    n_state   = ST_OUTER;
                end
            end
            ST_OUTER: begin
                if (r_u == r_n) begin
                    if (r_fcount == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit_idx = VW'(r_fcount - CW'(1));
                        n_state    = ST_EMIT_RD;
                    end
                end else if (r_visited[VW'(r_u)]) begin
                    n_u = r_u + CW'(1);
                end else begin
                    // start a new tree at this root
                    n_visited[VW'(r_u)] = 1'b1;
                    stk_we    = 1'b1;
                    stk_wdata = VW'(r_u);
                    n_top     = VW'(r_u);
                    n_depth   = CW'(1);
                    n_state   = ST_ADJ_RD;
                end
            end
            ST_ADJ_RD: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (pick.found && (r_depth < CW'(VERTICES))) begin
                    // descend to the lowest unvisited neighbor
                    n_visited[pick.index] = 1'b1;
                    stk_we    = 1'b1;
                    stk_wdata = pick.index;
                    n_top     = pick.index;
                    n_depth   = r_depth + CW'(1);
                    n_state   = ST_ADJ_RD;
                end else begin
                    // finish the top vertex and pop it
                    fin_we   = (r_fcount < CW'(VERTICES));
                    if (fin_we) begin
                        n_fcount = r_fcount + CW'(1);
                    end
                    n_depth  = r_depth - CW'(1);
                    if (r_depth == CW'(1)) begin
                        n_u     = r_u + CW'(1);
                        n_state = ST_OUTER;
                    end else begin
                        n_state = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD: begin
                n_top   = r_stk_q;
                n_state = ST_ADJ_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_data.vertex = r_fin_q;
                    n_out_data.last   = (r_emit_idx == '0);
                    if (r_emit_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx - VW'(1);
                        n_state    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_num_vertices <= 7'(VERTICES);
            r_n            <= '0;
            r_u            <= '0;
            r_depth        <= '0;
            r_fcount       <= '0;
            r_emit_idx     <= '0;
            r_visited      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_u         <= n_u;
            r_depth     <= n_depth;
            r_fcount    <= n_fcount;
            r_emit_idx  <= n_emit_idx;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num_vertices <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_span     <= n_span;
        r_out_data <= n_out_data;
    end

    // adjacency rows: one write port, registered read at the stack top
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            mem_adj[i_in_data.row_index] <= i_in_data.row_edges;
        end
        r_adj_q <= mem_adj[r_top];
    end

    // search stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[VW'(r_depth)] <= stk_wdata;
        end
        r_stk_q <= mem_stk[stk_raddr];
    end

    // finish order
    always_ff @(posedge i_clk) begin
        if (fin_we) begin
            mem_fin[VW'(r_fcount)] <= r_top;
        end
        r_fin_q <= mem_fin[r_emit_idx];
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[src/dfs_lowbit.sv]
// ---------------------------------------------------------------------------
// DFS lowest-bit picker
// Priority encoder that finds the lowest-numbered candidate neighbor.
// ---------------------------------------------------------------------------
module dfs_lowbit (
    input  logic [dfs_pkg::VERTICES-1:0] i_cand,
    output dfs_pkg::t_dfs_pick           o_pick
);
    import dfs_pkg::*;

    always_comb begin
        o_pick.found = |i_cand;
        o_pick.index = '0;
        // scan from the top so the lowest set bit wins
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (i_cand[i]) begin
                o_pick.index = VW'(i);
            end
        end
    end

endmodule

[src/dfs_checker.sv]
// ---------------------------------------------------------------------------
// DFS sort port checker
// Watches the ports of the DFS sort unit; attached by bind.
// ---------------------------------------------------------------------------
`include "dfs_topological_sort_unit_macros.svh"

module dfs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  dfs_pkg::t_dfs_req i_in_data,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  dfs_pkg::t_dfs_res o_out_data
);
    import dfs_pkg::*;

    logic in_beat;

    assign in_beat  = i_in_valid && !o_in_stall;

    // hold a stalled result beat
    `DFS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // a run beat makes the unit busy
    `DFS_ASSERT_NEXT(a_run_busy, in_beat && (i_in_data.req_type == REQ_RUN), o_in_stall)
    // a load beat leaves the unit ready
    `DFS_ASSERT_NEXT(a_load_ready, in_beat && (i_in_data.req_type == REQ_LOAD), !o_in_stall)
    // new results appear only while a run is in progress
    `DFS_ASSERT_NOW(a_out_in_run, $rose(o_out_valid), $past(o_in_stall))
    // write the vertex count only while the unit is idle and drained
    `DFS_ASSERT_NOW(a_cfg_idle, i_cfg_we, !o_in_stall && !o_out_valid)

endmodule

bind dfs_topological_sort_unit dfs_checker u_dfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[sim/tb_dfs_sort_pkg.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DFS sort order checker
// Tracks the adjacency rows and vertex count, predicts the emitted vertex
// order of every run beat and checks each result beat against it.
// ---------------------------------------------------------------------------
package tb_dfs_sort_pkg;

    import dfs_pkg::*;

    class topo_order_checker;
        logic [63:0] adj_rows [VERTICES];
        logic [6:0]  vertex_count;
        t_dfs_res    expected_order [$];
        int          errors;
        int          results_seen;

        function new();
            vertex_count = 7'd64;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_count(logic [6:0] n);
            vertex_count = n;
        endfunction

        function int pending();
            return expected_order.size();
        endfunction

        // Record one accepted request beat.
        function void note_beat(t_dfs_req req);
            if (req.req_type == REQ_LOAD) begin
                adj_rows[req.row_index] = req.row_edges;
            end else begin
                predict_order();
            end
        endfunction

        // Walk the graph depth first and queue the reverse finish order.
        function void predict_order();
            int          active;
            int          depth;
            int          v;
            logic [63:0] span;
            logic [63:0] seen;
            logic [63:0] cand;
            logic [5:0]  stack [VERTICES];
            logic [5:0]  top;
            logic [5:0]  finished [$];
            t_dfs_res    res;

            active = (vertex_count > VERTICES) ? VERTICES : int'(vertex_count);
            span   = (active >= 64) ? '1 : ((64'd1 << active) - 64'd1);
            seen   = '0;
            for (int u = 0; u < active; u++) begin
                if (!seen[u]) begin
                    seen[u]  = 1'b1;
                    stack[0] = 6'(u);
                    depth    = 1;
                    while (depth > 0) begin
                        top  = stack[depth-1];
                        cand = adj_rows[top] & ~seen & span;
                        if (cand != '0 && depth < VERTICES) begin
                            v = 0;
                            while (!cand[v]) v++;
                            seen[v]      = 1'b1;
                            stack[depth] = 6'(v);
                            depth++;
                        end else begin
                            depth--;
                            finished.push_back(top);
                        end
                    end
                end
            end
            for (int k = finished.size() - 1; k >= 0; k--) begin
                res.vertex = finished[k];
                res.last   = (k == 0);
                expected_order.push_back(res);
            end
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void check_beat(t_dfs_res got);
            t_dfs_res want;

            results_seen++;
            if (expected_order.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: vertex %0d last %0b",
                             got.vertex, got.last);
                return;
            end
            want = expected_order.pop_front();
            if (got.vertex !== want.vertex || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                             want.vertex, want.last, got.vertex, got.last);
            end
        endfunction
    endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DFS topological sort unit testbench
// Loads graphs of many shapes, runs the sort under several vertex counts and
// random idling on both channels, and checks every emitted vertex in order.
// ---------------------------------------------------------------------------
module tb_top;

    import dfs_pkg::*;
    import tb_dfs_sort_pkg::*;

    // Graph shapes used to build adjacency rows
    typedef enum int {
        SH_ZERO,
        SH_ONES,
        SH_RANDOM,
        SH_SPARSE,
        SH_DAG,
        SH_CHAIN,
        SH_BACK_CHAIN,
        SH_RING
    } t_row_shape;

    localparam int DRAIN_CYCLES = 1200;   // covers an unstalled 64-vertex run
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int PHASE_ITEMS  = 11;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_we;
    logic [6:0] i_cfg_data;
    logic     i_in_valid;
    logic     o_in_stall;
    t_dfs_req i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_dfs_res o_out_data;

    topo_order_checker sb;
    int        items_sent;
    int        burst_left;
    bit        row_loaded [VERTICES];
    logic [6:0] cur_count;
    bit        pressure_done;

    dfs_topological_sort_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run, even with every item a
    // 64-vertex run and every result beat held by the receiver.
    initial begin
        #25_000_000;
        $display("[dfs_topological_sort_unit] ERROR");
        $finish;
    end

    // Check every result beat the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_out_data);
    end

    // Receiver: change stall pattern every so often; once, after enough
    // results, hold off for a long stretch so the block backs up and keeps
    // its input stalled while the sender keeps offering.
    initial begin : receiver
        int mode;
        int span_len;

        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!pressure_done && sb.results_seen >= 60) begin
                pressure_done = 1'b1;
                i_out_stall <= 1'b1;
                for (int hold = 0; hold < HOLD_CYCLES; hold++) @(posedge i_clk);
            end else begin
                mode     = $urandom_range(0, 3);
                span_len = $urandom_range(20, 150);
                repeat (span_len) begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 2) == 0);
                        2: i_out_stall <= ~i_out_stall;
                        default: i_out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offer one request beat and hold it until accepted. Between bursts drop
    // valid for a random gap; long bursts give stretches with no idling.
    task automatic send_beat(t_dfs_req req);
        int gap;

        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(req);
        items_sent++;
        if (req.req_type == REQ_LOAD)
            row_loaded[req.row_index] = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic load_row(int r, logic [63:0] edges);
        t_dfs_req req;

        req.req_type  = REQ_LOAD;
        req.row_index = 6'(r);
        req.row_edges = edges;
        send_beat(req);
    endtask

    // Row index and edge fields are don't-care on a run: randomize them.
    task automatic run_sort();
        t_dfs_req req;

        req.req_type  = REQ_RUN;
        req.row_index = 6'($urandom);
        req.row_edges = {$urandom, $urandom};
        send_beat(req);
    endtask

    // Wait out every expected result plus the run latency, so the block is
    // idle even when the last beat produced nothing.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(logic [6:0] n);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_count(n);
        cur_count = n;
    endtask

    function automatic int active_count();
        return (cur_count > VERTICES) ? VERTICES : int'(cur_count);
    endfunction

    // Build one adjacency row of the given shape for a graph of 'active'
    // vertices; sometimes add junk above the graph that a run must ignore.
    function automatic logic [63:0] row_pattern(t_row_shape shape, int r, int active);
        logic [63:0] span;
        logic [63:0] edges;

        span  = (active >= 64) ? '1 : ((64'd1 << active) - 64'd1);
        edges = '0;
        case (shape)
            SH_ZERO:   edges = '0;
            SH_ONES:   edges = '1;
            SH_RANDOM: edges = {$urandom, $urandom};
            SH_SPARSE: begin
                if (active > 0)
                    repeat ($urandom_range(1, 3)) edges[$urandom_range(0, active - 1)] = 1'b1;
            end
            SH_DAG:        edges = {$urandom, $urandom} & span & ~((64'd2 << r) - 64'd1);
            SH_CHAIN:      if (r + 1 < active) edges[r+1] = 1'b1;
            SH_BACK_CHAIN: if (r > 0) edges[r-1] = 1'b1;
            default:       if (active > 0) edges[(r + 1) % active] = 1'b1;
        endcase
        if (shape != SH_ZERO && shape != SH_ONES && $urandom_range(0, 3) == 0)
            edges |= {$urandom, $urandom} & ~span;
        return edges;
    endfunction

    // Load every row a run can touch that has never been written.
    task automatic fill_rows();
        for (int r = 0; r < active_count(); r++)
            if (!row_loaded[r])
                load_row(r, row_pattern(t_row_shape'($urandom_range(0, 7)), r, active_count()));
    endtask

    // Well-formed sequence: rewrite a whole graph or a few rows, then run.
    task automatic graph_sequence();
        t_row_shape shape;
        bit         mixed;
        int         active;
        int         r;

        active = active_count();
        shape  = t_row_shape'($urandom_range(0, 7));
        mixed  = ($urandom_range(0, 3) == 0);
        if (active == 0) begin
            load_row($urandom_range(0, VERTICES - 1), {$urandom, $urandom});
        end else if (active <= 8 || $urandom_range(0, 2) == 0) begin
            for (r = 0; r < active; r++)
                load_row(r, row_pattern(mixed ? t_row_shape'($urandom_range(0, 7)) : shape,
                                        r, active));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                r = $urandom_range(0, active - 1);
                load_row(r, row_pattern(shape, r, active));
            end
        end
        run_sort();
    endtask

    // Noise: stray load anywhere in the row store, or a bare run.
    task automatic noise_beat();
        if ($urandom_range(0, 1) == 0)
            load_row($urandom_range(0, VERTICES - 1), {$urandom, $urandom});
        else
            run_sort();
    endtask

    task automatic random_phase(logic [6:0] n);
        int stop_at;

        set_count(n);
        fill_rows();
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7)
                graph_sequence();
            else
                noise_beat();
        end
    endtask

    initial begin : stimulus
        logic [6:0] plan [20];

        plan = '{7'd127, 7'd3, 7'd8, 7'd64, 7'd1, 7'd12, 7'd5, 7'd2, 7'd16, 7'd0,
                 7'd7, 7'd10, 7'd4, 7'd6, 7'd9, 7'd20, 7'd3, 7'd64, 7'd11, 7'd5};
        sb            = new();
        items_sent    = 0;
        burst_left    = 4;
        cur_count     = 7'd64;
        pressure_done = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 7'd64;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small graph: self loop with bits beyond the graph, an empty row,
        // and a two-vertex cycle.
        set_count(7'd4);
        load_row(0, '1);
        load_row(1, '0);
        load_row(2, 64'h0000_0000_0000_000A);
        load_row(3, 64'h0000_0000_0000_0004);
        run_sort();
        // Self loop on 3 plus the top edge bit, which is out of the graph.
        load_row(3, 64'h8000_0000_0000_0008);
        run_sort();
        // Single vertex with a self loop.
        set_count(7'd1);
        run_sort();
        // Zero vertices: a run emits nothing; loads still land.
        set_count(7'd0);
        run_sort();
        load_row(63, 64'h0000_0000_0000_0001);
        // Two-vertex cycle.
        set_count(7'd2);
        load_row(0, 64'h0000_0000_0000_0002);
        load_row(1, 64'h0000_0000_0000_0001);
        run_sort();

        foreach (plan[i])
            random_phase(plan[i]);

        // Drain: wait for every expected beat, then the run latency.
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[dfs_topological_sort_unit] OK");
        end else begin
            $display("[dfs_topological_sort_unit] ERROR");
        end
        $finish;
    end

endmodule
